[rtl/mqmf_pkg.sv]
`default_nettype none

package mqmf_pkg;

  // Field widths of one transaction
  localparam int unsigned CmdW     = 1;
  localparam int unsigned QueueNumW = 3;
  localparam int unsigned MsgIdW   = 32;
  localparam int unsigned PayloadW = 64;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CapW     = 8;

  // Message store word: payload over id
  localparam int unsigned EntryW   = MsgIdW + PayloadW;

  // Input stream tdata: queue_number, msg_id, payload, zero fill to bytes
  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = MsgIdW + PayloadW;

  // Capacity register after reset
  localparam logic [CapW-1:0] CapacityReset = 8'd100;

  // Commands
  localparam logic CMD_SEND = 1'b0;
  localparam logic CMD_GET  = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_DONE  = 2'd0,
    ST_BADQ  = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Outcome of one command, from queue control to the datapath
  typedef struct packed {
    status_e status;
    logic    wr_en;
    logic    rd_en;
  } queue_op_t;

endpackage

`default_nettype wire

[rtl/mqmf_store.sv]
`default_nettype none

module mqmf_store #(
  parameter int unsigned Entries = 512,
  parameter int unsigned AddrW   = 9
) (
  input  wire logic                          clk_i,
  input  wire logic                          wr_en_i,
  input  wire logic                          rd_en_i,
  input  wire logic [AddrW-1:0]              addr_i,
  input  wire logic [mqmf_pkg::EntryW-1:0]   wr_data_i,
  output logic      [mqmf_pkg::EntryW-1:0]   rd_data_o
);
  import mqmf_pkg::*;

  logic [EntryW-1:0] mem [Entries];
  logic [EntryW-1:0] rd_data_q;

  // Shared message store, one access per cycle, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[rtl/mqmf_queue_ctrl.sv]
`default_nettype none

module mqmf_queue_ctrl #(
  parameter int unsigned QueueCount = 4,
  parameter int unsigned QueueDepth = 128,
  parameter int unsigned AddrW      = 9
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           accept_i,
  input  wire logic                           cmd_i,
  input  wire logic [mqmf_pkg::QueueNumW-1:0] queue_num_i,
  input  wire logic [mqmf_pkg::CapW-1:0]      capacity_i,
  output mqmf_pkg::queue_op_t                 op_o,
  output logic      [AddrW-1:0]               addr_o
);
  import mqmf_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned XW   = (CntW > CapW) ? CntW : CapW;
  localparam int unsigned QW   = (QueueCount > 1) ? $clog2(QueueCount) : 1;
  localparam logic [XW-1:0]   DepthX = XW'(QueueDepth);
  localparam logic [AddrW-1:0] DepthA = AddrW'(QueueDepth);

  logic [PtrW-1:0] rd_ptr_q [QueueCount];
  logic [PtrW-1:0] wr_ptr_q [QueueCount];
  logic [CntW-1:0] fill_q   [QueueCount];

  logic [XW-1:0]   cap_raw;
  logic [CntW-1:0] cap;
  logic            q_ok;
  logic [QW-1:0]   qi;
  logic [PtrW-1:0] ptr_sel;
  logic [PtrW-1:0] ptr_next;
  logic [CntW-1:0] ptr_inc;
  logic [CntW-1:0] fill_sel;
  queue_op_t       op;

  // Effective capacity: zero acts as one, clamp at the queue depth
  assign cap_raw = XW'(capacity_i);
  always_comb begin
    if (cap_raw == '0) begin
      cap = CntW'(1);
    end else if (cap_raw > DepthX) begin
      cap = CntW'(QueueDepth);
    end else begin
      cap = CntW'(cap_raw);
    end
  end

  assign q_ok = ({1'b0, queue_num_i} < (QueueNumW + 1)'(QueueCount));
  assign qi   = QW'(queue_num_i);

  assign fill_sel = fill_q[qi];
  assign ptr_sel  = (cmd_i == CMD_GET) ? rd_ptr_q[qi] : wr_ptr_q[qi];

  // Pointer advance with wrap at capacity
  assign ptr_inc  = CntW'(ptr_sel) + CntW'(1);
  assign ptr_next = (ptr_inc >= cap) ? '0 : PtrW'(ptr_inc);

  // Decide the outcome of the command
  always_comb begin
    op.status = ST_DONE;
    op.wr_en  = 1'b0;
    op.rd_en  = 1'b0;
    if (!q_ok) begin
      op.status = ST_BADQ;
    end else if (cmd_i == CMD_SEND) begin
      if (fill_sel >= cap) begin
        op.status = ST_FULL;
      end else begin
        op.wr_en = 1'b1;
      end
    end else begin
      if (fill_sel == '0) begin
        op.status = ST_EMPTY;
      end else begin
        op.rd_en = 1'b1;
      end
    end
  end

  assign addr_o = AddrW'(qi) * DepthA + AddrW'(ptr_sel);
  assign op_o   = op;

  // Per-queue pointers and fill counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QueueCount; i++) begin
        rd_ptr_q[i] <= '0;
        wr_ptr_q[i] <= '0;
        fill_q[i]   <= '0;
      end
    end else if (accept_i) begin
      if (op.wr_en) begin
        wr_ptr_q[qi] <= ptr_next;
        fill_q[qi]   <= fill_sel + CntW'(1);
      end else if (op.rd_en) begin
        rd_ptr_q[qi] <= ptr_next;
        fill_q[qi]   <= fill_sel - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/multi_queue_message_fifo_core.sv]
`default_nettype none

// Multi-queue message FIFO. QUEUE_COUNT circular queues share one message
// store of QUEUE_COUNT*QUEUE_DEPTH entries; each entry holds a 32-bit id and
// a 64-bit payload. A send (tuser=0) appends to the selected queue or is
// dropped with status full; a get (tuser=1) returns the oldest entry or
// status empty; a queue number of QUEUE_COUNT or above gives status badq.
// Every command gives exactly one result. queue_capacity sets how many
// entries each queue uses (0 acts as 1, values above QUEUE_DEPTH act as
// QUEUE_DEPTH); write it only while no transaction is in flight. Entries
// held across a change stay in place, and pointers past the new capacity
// wrap by the same rule. A result passes through the store-read stage, then
// the output register. A new command is taken every cycle as long as the
// output side keeps up; the single store port and the per-queue pointer
// registers are updated at the accepting edge, so no command waits on another.
module multi_queue_message_fifo_core #(
  parameter int unsigned QUEUE_COUNT = 4,
  parameter int unsigned QUEUE_DEPTH = 128
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration
  input  wire logic                           cfg_wr_en_i,
  input  wire logic [mqmf_pkg::CapW-1:0]      cfg_wr_data_i,   // queue_capacity
  // Command stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [2:0] queue_number, [34:3] msg_id, [98:35] payload, [103:99] zero
  input  wire logic [mqmf_pkg::InDataW-1:0]   s_axis_tdata,
  input  wire logic [0:0]                     s_axis_tuser,    // [0] command
  // Result stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [31:0] out_msg_id, [95:32] out_payload
  output logic      [mqmf_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic      [mqmf_pkg::StatusW-1:0]   m_axis_tuser     // [1:0] status
);
  import mqmf_pkg::*;

  localparam int unsigned Entries = QUEUE_COUNT * QUEUE_DEPTH;
  localparam int unsigned AddrW   = (Entries > 1) ? $clog2(Entries) : 1;

  logic [CapW-1:0]      cap_q;
  logic                 accept;
  logic                 out_free;
  logic                 s1_move;
  logic [QueueNumW-1:0] in_queue;
  logic [MsgIdW-1:0]    in_msg_id;
  logic [PayloadW-1:0]  in_payload;
  queue_op_t            op;
  logic [AddrW-1:0]     addr;
  logic [EntryW-1:0]    rd_data;

  logic                 s1_valid_q;
  status_e              s1_status_q;
  logic                 s1_get_q;
  logic                 out_valid_q;
  status_e              out_status_q;
  logic [MsgIdW-1:0]    out_id_q;
  logic [PayloadW-1:0]  out_payload_q;

  assign in_queue   = s_axis_tdata[QueueNumW-1:0];
  assign in_msg_id  = s_axis_tdata[QueueNumW +: MsgIdW];
  assign in_payload = s_axis_tdata[QueueNumW + MsgIdW +: PayloadW];

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapacityReset;
    end else if (cfg_wr_en_i) begin
      cap_q <= cfg_wr_data_i;
    end
  end

  // Handshake: store stage advances when the output register frees up
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_move       = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  mqmf_queue_ctrl #(
    .QueueCount (QUEUE_COUNT),
    .QueueDepth (QUEUE_DEPTH),
    .AddrW      (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .cmd_i       (s_axis_tuser[0]),
    .queue_num_i (in_queue),
    .capacity_i  (cap_q),
    .op_o        (op),
    .addr_o      (addr)
  );

  mqmf_store #(
    .Entries (Entries),
    .AddrW   (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (accept && op.wr_en),
    .rd_en_i   (accept && op.rd_en),
    .addr_i    (addr),
    .wr_data_i ({in_payload, in_msg_id}),
    .rd_data_o (rd_data)
  );

  // Store-read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_status_q <= ST_DONE;
      s1_get_q    <= 1'b0;
    end else if (accept) begin
      s1_valid_q  <= 1'b1;
      s1_status_q <= op.status;
      s1_get_q    <= op.rd_en;
    end else if (s1_move) begin
      s1_valid_q  <= 1'b0;
    end
  end

  // Output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_status_q <= ST_DONE;
    end else if (s1_move) begin
      out_valid_q  <= 1'b1;
      out_status_q <= s1_status_q;
    end else if (m_axis_tready) begin
      out_valid_q  <= 1'b0;
    end
  end

  // Output payload, zero unless a get removed an entry
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_id_q      <= s1_get_q ? rd_data[MsgIdW-1:0] : '0;
      out_payload_q <= s1_get_q ? rd_data[MsgIdW +: PayloadW] : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {out_payload_q, out_id_q};

  // Checks
  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while store stage is blocked");

  a_fail_zero_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != ST_DONE) |-> (m_axis_tdata == '0))
    else $error("non-done result carries data");

  a_badq_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ({1'b0, in_queue} >= (QueueNumW + 1)'(QUEUE_COUNT)))
    |=> (s1_valid_q && s1_status_q == ST_BADQ && !s1_get_q))
    else $error("bad queue number not flagged");

  a_get_only_on_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_get_q |-> (s1_status_q == ST_DONE))
    else $error("store read pending on a failed command");

endmodule

`default_nettype wire

[sim/multi_queue_message_fifo_core_tb.sv]
module multi_queue_message_fifo_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mqmf_pkg::*;

  localparam int QC = 4;
  localparam int QD = 128;
  localparam int unsigned CycleLimit = 200000;

  // Tracks queue contents and the reply each command must produce
  class queue_reply_tracker;
    typedef struct packed {
      status_e     status;
      logic [31:0] id;
      logic [63:0] payload;
    } reply_t;

    reply_t      replies_due[$];
    logic [31:0] id_mem   [QC*QD];
    logic [63:0] data_mem [QC*QD];
    int          rd_ptr   [QC];
    int          wr_ptr   [QC];
    int          fill     [QC];
    logic [7:0]  capacity;
    int          errors;

    function new();
      capacity = CapacityReset;
      errors   = 0;
      for (int q = 0; q < QC; q++) begin
        rd_ptr[q] = 0;
        wr_ptr[q] = 0;
        fill[q]   = 0;
      end
    endfunction

    function void set_capacity(logic [7:0] value);
      capacity = value;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    function int fill_of(int q);
      return fill[q];
    endfunction

    // 0 acts as 1, anything above the queue depth acts as the depth
    function int eff_capacity();
      if (capacity == 0) return 1;
      if (capacity > QD) return QD;
      return int'(capacity);
    endfunction

    function int next_ptr(int p, int cap);
      return (p + 1 >= cap) ? 0 : p + 1;
    endfunction

    // Apply one accepted command and queue up its reply
    function void note_command(logic cmd, logic [2:0] qn, logic [31:0] id,
                               logic [63:0] pl);
      reply_t r;
      int     cap;
      int     slot;
      r.status  = ST_DONE;
      r.id      = '0;
      r.payload = '0;
      cap = eff_capacity();
      if (qn >= QC) begin
        r.status = ST_BADQ;
      end else if (cmd == CMD_SEND) begin
        if (fill[qn] >= cap) begin
          r.status = ST_FULL;
        end else begin
          slot = qn * QD + (wr_ptr[qn] % QD);
          id_mem[slot]   = id;
          data_mem[slot] = pl;
          wr_ptr[qn] = next_ptr(wr_ptr[qn], cap);
          fill[qn]++;
        end
      end else begin
        if (fill[qn] == 0) begin
          r.status = ST_EMPTY;
        end else begin
          slot = qn * QD + (rd_ptr[qn] % QD);
          r.id      = id_mem[slot];
          r.payload = data_mem[slot];
          rd_ptr[qn] = next_ptr(rd_ptr[qn], cap);
          fill[qn]--;
        end
      end
      replies_due.push_back(r);
    endfunction

    // Compare one result transaction against the oldest reply due
    function void check_result(logic [1:0] st, logic [31:0] id, logic [63:0] pl);
      reply_t r;
      if (replies_due.size() == 0) begin
        $error("result with no command outstanding: status %0d id %h payload %h",
               st, id, pl);
        errors++;
        return;
      end
      r = replies_due.pop_front();
      if (st !== r.status) begin
        $error("status: expected %0d, actual %0d", r.status, st);
        errors++;
      end
      if (id !== r.id) begin
        $error("out_msg_id: expected %h, actual %h", r.id, id);
        errors++;
      end
      if (pl !== r.payload) begin
        $error("out_payload: expected %h, actual %h", r.payload, pl);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_wr_en_i;
  logic [CapW-1:0]     cfg_wr_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // [2:0] queue_number, [34:3] msg_id, [98:35] payload
  logic [0:0]          s_axis_tuser;   // [0] command
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // [31:0] out_msg_id, [95:32] out_payload
  logic [StatusW-1:0]  m_axis_tuser;   // [1:0] status

  queue_reply_tracker sb;
  bit                 gaps_on;
  bit                 long_hold;
  int unsigned        cycle_count;

  multi_queue_message_fifo_core #(
    .QUEUE_COUNT(QC),
    .QUEUE_DEPTH(QD)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_wr_data_i(cfg_wr_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle counter and watchdog
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Some tests failed");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        stall_left = 300;
        long_hold  = 1'b0;
      end else if (stall_left == 0 && gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[95:32]);
  end

  // Offer one command transaction; entered just after a rising edge
  task automatic send_command(logic cmd, logic [2:0] qn, logic [31:0] id,
                              logic [63:0] pl);
    int gap;
    @(negedge clk_i);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, pl, id, qn};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(cmd, qn, id, pl);
  endtask

  task automatic idle_sender();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // Capacity write once every reply is in and the pipeline has settled
  task automatic write_capacity(logic [7:0] value);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    sb.set_capacity(value);
  endtask

  // Empty every queue so pointers stay in step across capacity changes
  task automatic drain_queues();
    for (int q = 0; q < QC; q++) begin
      while (sb.fill_of(q) != 0)
        send_command(CMD_GET, q[2:0], $urandom, {$urandom, $urandom});
    end
  endtask

  task automatic begin_phase(logic [7:0] cap, bit gaps);
    drain_queues();
    idle_sender();
    write_capacity(cap);
    gaps_on = gaps;
  endtask

  // Random mix; focus_q < 0 spreads commands over all queues
  task automatic run_phase(int count, int send_pct, int focus_q, int focus_pct);
    logic       cmd;
    logic [2:0] qn;
    for (int i = 0; i < count; i++) begin
      cmd = ($urandom_range(0, 99) < send_pct) ? CMD_SEND : CMD_GET;
      if ($urandom_range(0, 99) < 8)
        qn = 3'($urandom_range(QC, 7));
      else if (focus_q >= 0 && $urandom_range(0, 99) < focus_pct)
        qn = 3'(focus_q);
      else
        qn = 3'($urandom_range(0, QC - 1));
      send_command(cmd, qn, $urandom, {$urandom, $urandom});
    end
  endtask

  task automatic directed_checks();
    // Get from an empty queue
    send_command(CMD_GET, 3'd0, '0, '0);
    // Out-of-range queue numbers leave all queues alone
    send_command(CMD_SEND, 3'd4, '1, '1);
    send_command(CMD_GET, 3'd7, '1, '1);
    send_command(CMD_SEND, 3'd7, '0, '0);
    send_command(CMD_GET, 3'd5, 32'h5a5a_a5a5, 64'ha5a5_5a5a_0f0f_f0f0);
    // Extreme ids and payloads
    send_command(CMD_SEND, 3'd3, '0, '0);
    send_command(CMD_SEND, 3'd2, '1, '1);
    send_command(CMD_GET, 3'd3, '1, '1);
    send_command(CMD_GET, 3'd2, '0, '0);
    // Capacity 0 behaves as 1
    idle_sender();
    write_capacity(8'd0);
    send_command(CMD_SEND, 3'd1, 32'h0000_0001, 64'h1);
    send_command(CMD_SEND, 3'd1, 32'h0000_0002, 64'h2);
    send_command(CMD_GET, 3'd1, '0, '0);
    send_command(CMD_GET, 3'd1, '0, '0);
    // Fill queue 0, then shrink capacity while it still holds entries
    idle_sender();
    write_capacity(8'd4);
    repeat (5) send_command(CMD_SEND, 3'd0, $urandom, {$urandom, $urandom});
    send_command(CMD_GET, 3'd0, '0, '0);
    idle_sender();
    write_capacity(8'd2);
    send_command(CMD_SEND, 3'd0, $urandom, {$urandom, $urandom});
    repeat (4) send_command(CMD_GET, 3'd0, '0, '0);
  endtask

  // Main sequence
  initial begin
    sb            = new();
    gaps_on       = 1'b1;
    long_hold     = 1'b0;
    cycle_count   = 0;
    rst_ni        = 1'b0;
    cfg_wr_en_i   = 1'b0;
    cfg_wr_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    directed_checks();

    // Largest capacity, pushed to full on one queue
    begin_phase(8'd255, 1'b1);
    run_phase(170, 95, 2, 95);
    begin_phase(8'd1, 1'b1);
    long_hold = 1'b1;
    run_phase(20, 55, -1, 0);
    begin_phase(8'd2, 1'b0);
    run_phase(20, 55, 1, 60);
    begin_phase(8'd5, 1'b1);
    run_phase(20, 60, -1, 0);
    begin_phase(8'd128, 1'b1);
    run_phase(20, 70, 3, 70);
    begin_phase(8'd12, 1'b0);
    run_phase(20, 55, -1, 0);
    begin_phase(8'd0, 1'b1);
    run_phase(20, 50, 0, 50);
    begin_phase(8'd3, 1'b1);
    run_phase(20, 60, -1, 0);
    begin_phase(8'd64, 1'b1);
    run_phase(20, 65, -1, 0);
    // Final stretch without idling on either side
    begin_phase(8'd9, 1'b0);
    run_phase(20, 55, -1, 0);
    drain_queues();
    idle_sender();

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[files.f]
rtl/mqmf_pkg.sv
rtl/mqmf_store.sv
rtl/mqmf_queue_ctrl.sv
rtl/multi_queue_message_fifo_core.sv
sim/multi_queue_message_fifo_core_tb.sv
